// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, off during rst
`define BCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication sampled on clk, off during rst
`define BCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/bcp_pkg.sv -----
// types and constants for the binomial coefficient block
`default_nettype none

package bcp_pkg;

  localparam int N_W   = 6;
  localparam int K_W   = N_W + 1;
  localparam int VAL_W = 64;
  localparam int DEPTH = 1 << N_W;

  typedef struct packed {
    logic           valid;
    logic [K_W-1:0] k;
    logic           first;
    logic           edge_one;
    logic           capture;
    logic           fin;
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/bcp_if.sv -----
// request and response channel interfaces
`default_nettype none

interface bcp_req_if;
  logic                    valid;
  logic                    ready;
  logic [bcp_pkg::N_W-1:0] n;
  logic [bcp_pkg::N_W-1:0] r;

  modport source (output valid, output n, output r, input ready);
  modport sink (input valid, input n, input r, output ready);
endinterface

interface bcp_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bcp_pkg::VAL_W-1:0] value;
  logic                      invalid;

  modport source (output valid, output value, output invalid, input ready);
  modport sink (input valid, input value, input invalid, output ready);
endinterface

`default_nettype wire

// ----- rtl/bcp_row_mem.sv -----
// row store: one write port, one registered read port
`default_nettype none

module bcp_row_mem (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [bcp_pkg::N_W-1:0]   rd_addr,
  output logic      [bcp_pkg::VAL_W-1:0] rd_data,
  input  wire logic                      wr_en,
  input  wire logic [bcp_pkg::N_W-1:0]   wr_addr,
  input  wire logic [bcp_pkg::VAL_W-1:0] wr_data
);

  logic [bcp_pkg::VAL_W-1:0] mem [bcp_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcp_seq.sv -----
// row and column sequencer: issues one store read per step above column 0, descending columns
`default_nettype none

module bcp_seq (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [bcp_pkg::N_W-1:0] n,
  input  wire logic [bcp_pkg::N_W-1:0] r,
  output bcp_pkg::step_t               step,
  output logic                         rd_en,
  output logic [bcp_pkg::N_W-1:0]      rd_addr
);

  logic                    busy;
  logic [bcp_pkg::N_W-1:0] row;
  logic [bcp_pkg::K_W-1:0] k;
  logic [bcp_pkg::N_W-1:0] n_q;
  logic [bcp_pkg::N_W-1:0] r_q;

  logic [bcp_pkg::N_W-1:0] top_cur;
  logic [bcp_pkg::N_W-1:0] row_inc;
  logic [bcp_pkg::N_W-1:0] top_inc;
  logic [bcp_pkg::K_W-1:0] k_dec;
  logic                    last_row;

  assign top_cur  = (row < r_q) ? row : r_q;
  assign row_inc  = row + bcp_pkg::N_W'(1);
  assign top_inc  = (row_inc < r_q) ? row_inc : r_q;
  assign k_dec    = k - bcp_pkg::K_W'(1);
  assign last_row = (row == n_q);

  always_comb begin
    step.valid    = busy;
    step.k        = k;
    step.first    = (k == ({1'b0, top_cur} + bcp_pkg::K_W'(1)));
    step.edge_one = (k == '0) || (k == {1'b0, row});
    step.capture  = last_row && (k == {1'b0, r_q});
    step.fin      = last_row && (k == '0);
  end

  assign rd_en   = busy && (k != '0);
  assign rd_addr = k_dec[bcp_pkg::N_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
      k    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      row  <= '0;
      k    <= bcp_pkg::K_W'(1);
    end else if (busy) begin
      if (k == '0) begin
        if (last_row) begin
          busy <= 1'b0;
        end else begin
          row <= row_inc;
          k   <= {1'b0, top_inc} + bcp_pkg::K_W'(1);
        end
      end else begin
        k <= k_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_q <= n;
      r_q <= r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcp_upd.sv -----
// update stage: adds neighbor entries and writes the new row back
`default_nettype none

module bcp_upd (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bcp_pkg::step_t            step,
  input  wire logic [bcp_pkg::VAL_W-1:0] rd_data,
  output logic                           wr_en,
  output logic      [bcp_pkg::N_W-1:0]   wr_addr,
  output logic      [bcp_pkg::VAL_W-1:0] wr_data,
  output logic      [bcp_pkg::VAL_W-1:0] result,
  output logic                           done
);

  bcp_pkg::step_t            p;
  logic [bcp_pkg::VAL_W-1:0] hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
    end else begin
      p <= step;
    end
  end

  assign wr_en   = p.valid && !p.first;
  assign wr_addr = p.k[bcp_pkg::N_W-1:0];
  assign wr_data = p.edge_one ? bcp_pkg::VAL_W'(1) : (hold + rd_data);
  assign done    = p.valid && p.fin;

  always_ff @(posedge clk) begin
    if (p.valid) begin
      hold <= rd_data;
    end
    if (wr_en && p.capture) begin
      result <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/binomial_coefficient_pascal.sv -----
// Binomial coefficient C(n, r) by Pascal's triangle over a row store.
// req carries the pair n, r; rsp returns value and invalid, one item per request.
// One request is worked at a time. The row store is a 64 x 64-bit memory with
// one read and one write port; row i walks columns min(i, r)+1 down to 0, one
// step per cycle with a read at every step above column 0, and the adder
// writes each new entry back from the registered read data. Rows follow each
// other with no gap. r greater than n (or n above MAX_N) answers 0 with
// invalid set and leaves the store alone.
// req.ready is high whenever no request is in work; a result waiting in the
// output register does not block a new request. When rsp stalls, the next
// result waits until the output register is free.
// Reset clears the control state; the store keeps no contents across requests
// that matter, so it needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module binomial_coefficient_pascal #(
  parameter int MAX_N = 63
) (
  input wire logic  clk,
  input wire logic  rst,
  bcp_req_if.sink   req,
  bcp_rsp_if.source rsp
);

  localparam logic [bcp_pkg::K_W-1:0] MaxN =
    (MAX_N > 63) ? bcp_pkg::K_W'(63) : bcp_pkg::K_W'(MAX_N);

  bcp_pkg::state_t state;
  bcp_pkg::state_t state_next;

  logic accept;
  logic bad_pair;
  logic start;
  logic load_out;
  logic bad_q;

  bcp_pkg::step_t            step;
  logic                      rd_en;
  logic [bcp_pkg::N_W-1:0]   rd_addr;
  logic [bcp_pkg::VAL_W-1:0] rd_data;
  logic                      wr_en;
  logic [bcp_pkg::N_W-1:0]   wr_addr;
  logic [bcp_pkg::VAL_W-1:0] wr_data;
  logic [bcp_pkg::VAL_W-1:0] result;
  logic                      done;

  logic                      out_valid;
  logic [bcp_pkg::VAL_W-1:0] out_value;
  logic                      out_invalid;

  assign accept   = req.valid && req.ready;
  assign bad_pair = (req.r > req.n) || ({1'b0, req.n} > MaxN);

  always_comb begin
    state_next = state;
    unique case (state)
      bcp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = bad_pair ? bcp_pkg::ST_DONE : bcp_pkg::ST_RUN;
        end
      end
      bcp_pkg::ST_RUN: begin
        if (done) begin
          state_next = bcp_pkg::ST_DONE;
        end
      end
      bcp_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = bcp_pkg::ST_IDLE;
        end
      end
      default: state_next = bcp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      bcp_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        start     = req.valid && !bad_pair;
      end
      bcp_pkg::ST_RUN: begin
        req.ready = 1'b0;
      end
      bcp_pkg::ST_DONE: begin
        load_out = !out_valid || rsp.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bad_q <= bad_pair;
    end
  end

  bcp_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .n       (req.n),
    .r       (req.r),
    .step    (step),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  bcp_row_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bcp_upd u_upd (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .result  (result),
    .done    (done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value   <= bad_q ? '0 : result;
      out_invalid <= bad_q;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.value   = out_value;
  assign rsp.invalid = out_invalid;

  `BCP_ASSERT_IMP(a_done_in_run, done, state == bcp_pkg::ST_RUN, "row walk ended outside run")
  `BCP_ASSERT_IMP(a_step_in_run, step.valid, state == bcp_pkg::ST_RUN, "step issued outside run")
  `BCP_ASSERT_IMP(a_invalid_zero, rsp.valid && rsp.invalid, rsp.value == '0,
                  "invalid item carries nonzero value")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// testbench for binomial_coefficient_pascal: directed and random (n, r) pairs vs pascal predictor
`timescale 1ns / 100ps

module tb;

  localparam int MAX_ROW = 63;

  typedef struct {
    logic [bcp_pkg::VAL_W-1:0] value;
    logic                      invalid;
  } coef_t;

  logic clk;
  logic rst;

  bcp_req_if req_ch ();
  bcp_rsp_if rsp_ch ();

  binomial_coefficient_pascal #(
    .MAX_N(MAX_ROW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  coef_t       pending_coefs[$];
  int          mismatches = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // pascal row built in place, columns 0..r only
  function automatic coef_t predict_coef(input logic [5:0] n, input logic [5:0] r);
    logic [bcp_pkg::VAL_W-1:0] row [64];
    coef_t res;
    int top;
    res.value = '0;
    res.invalid = 1'b1;
    if (r > n || n > MAX_ROW) return res;
    for (int i = 0; i <= n; i++) begin
      top = (i < r) ? i : r;
      for (int j = top; j >= 0; j--) begin
        if (j == 0 || j == i) begin
          row[j] = 64'd1;
        end else begin
          row[j] = row[j] + row[j-1];
        end
      end
    end
    res.value = row[r];
    res.invalid = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    coef_t exp_c;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_coefs.size() == 0) begin
        $error("unexpected item: value %0d invalid %0b", rsp_ch.value, rsp_ch.invalid);
        mismatches++;
      end else begin
        exp_c = pending_coefs.pop_front();
        if (rsp_ch.value !== exp_c.value) begin
          $error("value: expected %0d, actual %0d", exp_c.value, rsp_ch.value);
          mismatches++;
        end
        if (rsp_ch.invalid !== exp_c.invalid) begin
          $error("invalid: expected %0b, actual %0b", exp_c.invalid, rsp_ch.invalid);
          mismatches++;
        end
      end
    end
  end

  task automatic send_pair(input logic [5:0] n, input logic [5:0] r);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.n <= n;
    req_ch.r <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_coefs.push_back(predict_coef(n, r));
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_edges();
    send_pair(6'd0, 6'd0);
    send_pair(6'd63, 6'd0);
    send_pair(6'd63, 6'd63);
    send_pair(6'd1, 6'd0);
    send_pair(6'd1, 6'd1);
    send_pair(6'd5, 6'd5);
    send_pair(6'd63, 6'd1);
    send_pair(6'd63, 6'd62);
  endtask

  task automatic test_invalid();
    send_pair(6'd0, 6'd1);
    send_pair(6'd0, 6'd63);
    send_pair(6'd62, 6'd63);
    send_pair(6'd10, 6'd11);
    send_pair(6'd1, 6'd2);
    send_pair(6'd21, 6'd42);
  endtask

  task automatic test_large_rows();
    send_pair(6'd63, 6'd31);
    send_pair(6'd63, 6'd32);
    send_pair(6'd62, 6'd31);
    send_pair(6'd42, 6'd21);
    send_pair(6'd32, 6'd16);
    send_pair(6'd2, 6'd1);
  endtask

  task automatic test_random(input int count);
    int unsigned pick;
    logic [5:0] n;
    logic [5:0] r;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        n = 6'($urandom_range(15));
        r = 6'($urandom_range(n));
      end else if (pick < 85) begin
        n = 6'($urandom_range(62));
        r = 6'($urandom_range(63, n + 1));
      end else if (pick < 95) begin
        n = 6'($urandom_range(40, 16));
        r = 6'($urandom_range(n));
      end else begin
        n = 6'($urandom_range(63, 41));
        r = 6'($urandom_range(63));
      end
      send_pair(n, r);
    end
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.n <= '0;
    req_ch.r <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 33;
    recv_stall_pct = 85;
    test_edges();
    test_invalid();
    test_large_rows();
    test_random(75);
    drain_results();

    send_gap_pct = 85;
    recv_stall_pct = 33;
    test_random(95);
    drain_results();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random(95);
    drain_results();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bcp_pkg.sv
rtl/bcp_if.sv
rtl/bcp_row_mem.sv
rtl/bcp_seq.sv
rtl/bcp_upd.sv
rtl/binomial_coefficient_pascal.sv
verif/tb.sv
